@@ rtl/ftc_pkg.sv @@
// Shared constants and types for the frequency top-three counter.
// No dependencies; compiled first.
`default_nettype none
package ftc_pkg;
    localparam int TableDepth = 64;
    localparam int CountBits  = 16;
    localparam int TopGroups  = 3;
    localparam int IdxBits    = $clog2(TableDepth);
    localparam int OccBits    = $clog2(TableDepth + 1);
    localparam int GrpBits    = $clog2(TopGroups + 1);
    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    localparam logic CmdAdd    = 1'b0;
    localparam logic CmdReport = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] count;
        logic [1:0]  rank;
        logic        none;
        logic        overflow;
        logic        last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic add;         // match in_value, update occupancy, read its count
        logic add_wr;      // write back the count read by add
        logic scan_start;  // clear scan accumulators, index to 0
        logic scan_step;   // examine entry at scan index
        logic max_mode;    // 1: find max count below limit; 0: find next key
        logic set_best;    // latch found max as current group count
        logic set_last;    // latch picked key as last emitted
        logic clr_have;    // start new group
    } ftc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic best_zero;
        logic empty;
    } ftc_stat_t;
endpackage
`default_nettype wire

@@ rtl/ftc_if.sv @@
// Valid/ready channel carrying one word of type T.
// Depends on nothing; used with ftc_pkg types.
`default_nettype none
interface ftc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/ftc_datapath.sv @@
// Table storage, parallel add match, and serial report scan.
// Depends on ftc_pkg.
`default_nettype none
module ftc_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [31:0]        in_value,
    input  ftc_pkg::ftc_cmd_t       cmd,
    output ftc_pkg::ftc_stat_t      stat,
    output logic [31:0]             pick_value,
    output logic [ftc_pkg::CountBits-1:0] pick_count,
    output logic                    overflow
);
    import ftc_pkg::*;

    logic [31:0]          keys_reg   [TableDepth];
    logic [CountBits-1:0] counts_reg [TableDepth];
    logic [OccBits-1:0]   occ_reg;
    logic                 ovf_reg;

    logic [IdxBits-1:0]   upd_idx_reg;
    logic                 upd_hit_reg, upd_en_reg;
    logic [CountBits-1:0] upd_cnt_reg;

    logic [OccBits-1:0]   idx_reg;
    logic                 rd_valid_reg;
    logic [31:0]          rd_key_reg;
    logic [CountBits-1:0] rd_cnt_reg;
    logic [CountBits:0]   limit_reg;    // one bit wider to hold max+1
    logic [CountBits-1:0] best_reg, acc_max_reg;
    logic [31:0]          last_b_reg, pick_b_reg, pick_val_reg;
    logic [CountBits-1:0] pick_cnt_reg;
    logic                 have_reg, found_reg;

    // add: parallel compare
    logic [TableDepth-1:0] hit;
    logic [IdxBits-1:0]    hit_idx;
    logic                  any_hit;
    always_comb
    begin
        hit_idx = '0;
        any_hit = 1'b0;
        for (int i = 0; i < TableDepth; i++)
        begin
            hit[i] = (OccBits'(i) < occ_reg) && (keys_reg[i] == in_value);
        end
        for (int i = TableDepth - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = IdxBits'(i);
                any_hit = 1'b1;
            end
        end
    end

    logic        table_full;
    logic        scan_issue;
    logic [31:0] rd_b;
    assign table_full = (occ_reg == OccBits'(TableDepth));
    assign scan_issue = cmd.scan_step && (idx_reg < occ_reg);
    assign rd_b       = rd_key_reg ^ 32'h8000_0000;

    always_ff @(posedge clk)
    begin
        if (cmd.add && !any_hit && !table_full)
        begin
            keys_reg[occ_reg[IdxBits-1:0]] <= in_value;
        end
        // add_wr: write back the count read by add
        if (cmd.add_wr && upd_en_reg)
        begin
            if (!upd_hit_reg)
                counts_reg[upd_idx_reg] <= CountBits'(1);
            else if (upd_cnt_reg != CountMax)
                counts_reg[upd_idx_reg] <= upd_cnt_reg + 1'b1;
        end
        if (cmd.add)
        begin
            upd_cnt_reg <= counts_reg[hit_idx];
        end
        rd_key_reg <= keys_reg[idx_reg[IdxBits-1:0]];
        rd_cnt_reg <= counts_reg[idx_reg[IdxBits-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            ovf_reg   <= 1'b0;
            upd_idx_reg <= '0;
            upd_hit_reg <= 1'b0;
            upd_en_reg  <= 1'b0;
            idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            limit_reg <= '0;
            best_reg  <= '0;
            acc_max_reg <= '0;
            have_reg  <= 1'b0;
            found_reg <= 1'b0;
            last_b_reg <= '0;
            pick_b_reg <= '0;
            pick_val_reg <= '0;
            pick_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.add)
            begin
                upd_hit_reg <= any_hit;
                upd_en_reg  <= any_hit || !table_full;
                upd_idx_reg <= any_hit ? hit_idx : occ_reg[IdxBits-1:0];
                if (!any_hit)
                begin
                    if (!table_full)
                        occ_reg <= occ_reg + 1'b1;
                    else
                        ovf_reg <= 1'b1;
                end
            end
            if (cmd.clr_have)
            begin
                have_reg <= 1'b0;
            end
            if (cmd.set_best)
            begin
                best_reg  <= acc_max_reg;
                limit_reg <= {1'b0, acc_max_reg};
            end
            if (cmd.set_last)
            begin
                have_reg   <= 1'b1;
                last_b_reg <= pick_b_reg;
            end
            if (cmd.scan_start)
            begin
                idx_reg      <= '0;
                rd_valid_reg <= 1'b0;
                acc_max_reg  <= '0;
                found_reg    <= 1'b0;
                if (cmd.max_mode && cmd.clr_have && !cmd.set_best)
                    limit_reg <= {1'b1, {CountBits{1'b0}}};
            end
            else
            begin
                // read one entry per cycle, judge it the cycle after
                rd_valid_reg <= scan_issue;
                if (scan_issue)
                    idx_reg <= idx_reg + 1'b1;
                if (rd_valid_reg)
                begin
                    if (cmd.max_mode)
                    begin
                        if ({1'b0, rd_cnt_reg} < limit_reg && rd_cnt_reg > acc_max_reg)
                            acc_max_reg <= rd_cnt_reg;
                    end
                    else if (rd_cnt_reg == best_reg && !(have_reg && rd_b <= last_b_reg)
                             && (!found_reg || rd_b < pick_b_reg))
                    begin
                        found_reg    <= 1'b1;
                        pick_b_reg   <= rd_b;
                        pick_val_reg <= rd_key_reg;
                        pick_cnt_reg <= rd_cnt_reg;
                    end
                end
            end
        end
    end

    assign stat.scan_done = (idx_reg >= occ_reg) && !rd_valid_reg;
    assign stat.found     = found_reg;
    assign stat.best_zero = (acc_max_reg == '0);
    assign stat.empty     = (occ_reg == '0);
    assign pick_value     = pick_val_reg;
    assign pick_count     = pick_cnt_reg;
    assign overflow       = ovf_reg;
endmodule
`default_nettype wire

@@ rtl/ftc_ctrl.sv @@
// Sequencer for add and report words; drives the result register.
// Depends on ftc_pkg.
`default_nettype none
module ftc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_cmd,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ftc_pkg::result_t        out_data,
    output ftc_pkg::ftc_cmd_t       cmd,
    input  ftc_pkg::ftc_stat_t      stat,
    input  wire logic [31:0]        pick_value,
    input  wire logic [ftc_pkg::CountBits-1:0] pick_count,
    input  wire logic               overflow
);
    import ftc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_MAX, S_MAXEND, S_KEY, S_KEYEND, S_EMIT, S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic [GrpBits-1:0] grp_reg, grp_next;
    logic [OccBits-1:0] n_reg, n_next;
    logic     pend_reg, pend_next;   // result held back until next one known
    result_t  pend_data_reg, pend_data_next;
    logic     ov_reg, ov_next;
    result_t  od_reg, od_next;
    logic     emit_ok;

    assign emit_ok = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;

    always_comb
    begin
        state_next = state_reg;
        grp_next = grp_reg;
        n_next = n_reg;
        pend_next = pend_reg;
        pend_data_next = pend_data_reg;
        ov_next = ov_reg && !out_ready;
        od_next = od_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_cmd == CmdAdd)
                    begin
                        cmd.add = 1'b1;
                        state_next = S_ADD;
                    end
                    else if (stat.empty)
                    begin
                        ov_next = 1'b1;
                        od_next = '{value: '0, count: '0, rank: '0, none: 1'b1,
                                    overflow: overflow, last: 1'b1};
                    end
                    else
                    begin
                        grp_next = '0;
                        n_next = '0;
                        pend_next = 1'b0;
                        cmd.scan_start = 1'b1;
                        cmd.max_mode = 1'b1;
                        cmd.clr_have = 1'b1;
                        state_next = S_MAX;
                    end
                end
            end
            S_ADD:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_MAX:
            begin
                cmd.max_mode = 1'b1;
                if (stat.scan_done)
                    state_next = S_MAXEND;
                else
                    cmd.scan_step = 1'b1;
            end
            S_MAXEND:
            begin
                if (stat.best_zero)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.set_best = 1'b1;
                    cmd.clr_have = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                if (stat.scan_done)
                    state_next = S_KEYEND;
                else
                    cmd.scan_step = 1'b1;
            end
            S_KEYEND:
            begin
                if (!stat.found || n_reg == OccBits'(TableDepth))
                begin
                    grp_next = grp_reg + 1'b1;
                    if (grp_reg + 1'b1 == GrpBits'(TopGroups))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.max_mode = 1'b1;
                        state_next = S_MAX;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // emit previous pending word, hold the new one
                if (!pend_reg || emit_ok)
                begin
                    if (pend_reg)
                    begin
                        ov_next = 1'b1;
                        od_next = pend_data_reg;
                    end
                    pend_next = 1'b1;
                    pend_data_next = '{value: pick_value, count: 16'(pick_count),
                                       rank: 2'(grp_reg + 1'b1), none: 1'b0,
                                       overflow: overflow, last: 1'b0};
                    n_next = n_reg + 1'b1;
                    cmd.set_last = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next = S_KEY;
                end
            end
            S_FLUSH:
            begin
                if (emit_ok)
                begin
                    ov_next = 1'b1;
                    od_next = pend_data_reg;
                    od_next.last = 1'b1;
                    pend_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grp_reg <= '0;
            n_reg <= '0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            pend_data_reg <= '0;
            od_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg <= grp_next;
            n_reg <= n_next;
            pend_reg <= pend_next;
            ov_reg <= ov_next;
            pend_data_reg <= pend_data_next;
            od_reg <= od_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/frequency_top3_counter_top.sv @@
// Top level of the frequency top-three counter.
// Depends on ftc_pkg, ftc_if, ftc_ctrl and ftc_datapath.
`default_nettype none
// On the accepting cycle of an add word the value is matched against all 64
// entries in parallel, occupancy is updated and the matching count is read
// into a register; the next cycle writes the count back, and the input
// reopens after it. A report walks the table through a registered read, one
// entry per cycle; after each pass a decision state follows, and a pass that
// finds an entry goes through an emit state. There is one pass to find each
// group's count, one per reported entry and one closing pass per group.
// Results leave through an output register, held one word back so the last
// one can be marked; the input waits while a result is pending.
module frequency_top3_counter_top (
    input wire logic clk,
    input wire logic rst_n,
    ftc_if.sink      in_ch,
    ftc_if.source    out_ch
);
    import ftc_pkg::*;

    ftc_cmd_t  cmd;
    ftc_stat_t stat;
    logic [31:0] pick_value;
    logic [CountBits-1:0] pick_count;
    logic overflow;

    ftc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_value(in_ch.data.value),
        .cmd(cmd), .stat(stat), .pick_value(pick_value),
        .pick_count(pick_count), .overflow(overflow)
    );

    ftc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_cmd(in_ch.data.cmd), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cmd(cmd), .stat(stat), .pick_value(pick_value),
        .pick_count(pick_count), .overflow(overflow)
    );
endmodule
`default_nettype wire
